>>> hdl/ogma_pkg.sv
package ogma_pkg;

  // Default build of the filter
  localparam int WINDOW_LEN_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 12;

  // Field widths of the channels
  localparam int NOW_W    = 32;
  localparam int ADC_W    = 12;
  localparam int FILT_W   = 12;
  localparam int INTV_W   = 16;
  localparam int THR_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_THRESH  = 2'd1;

  // Reset values of the configuration registers
  localparam logic [INTV_W-1:0] INTERVAL_RST  = 16'd100;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd32;

  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
    logic [ADC_W-1:0] adc_sample;
  } ogma_in_t;

  typedef struct packed {
    logic [FILT_W-1:0] filtered_value;
    logic              sampled;
    logic              accepted;
  } ogma_out_t;

  // Status of one processed transaction, core to output stage
  typedef struct packed {
    logic sampled;
    logic accepted;
  } ogma_flags_t;

endpackage

>>> hdl/ogma_core.sv
module ogma_core #(
  parameter int WINDOW_LEN  = ogma_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = ogma_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        proc_en,
  input  ogma_pkg::ogma_in_t          item,
  input  logic [ogma_pkg::INTV_W-1:0] interval,
  input  logic [ogma_pkg::THR_W-1:0]  threshold,
  output logic [SUM_W-1:0]            sum_out,
  output ogma_pkg::ogma_flags_t       flags_out
);
  import ogma_pkg::*;

  localparam int POS_W = $clog2(WINDOW_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

  // Ring storage: no reset, entries are valid only once the pointer has wrapped
  logic [SAMPLE_BITS-1:0] ring_r [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] rd_r;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, rd_addr;
  logic              wrapped_r, wrapped_nxt;
  logic [NOW_W-1:0]  last_r, last_nxt;
  logic [SUM_W-1:0]  sum_out_r;
  ogma_flags_t       flags_r;

  logic [SAMPLE_BITS-1:0] sample, oldest;
  logic [NOW_W-1:0]       elapsed;
  logic                   examine, take;
  logic [SUM_W-1:0]       scaled, dev;
  logic [SUM_W+THR_W-1:0] dev_x16, sum_x_thr;

  always_comb begin
    sample   = SAMPLE_BITS'(item.adc_sample);
    oldest   = wrapped_r ? rd_r : '0;
    elapsed  = item.now_ms - last_r;
    examine  = (elapsed >= NOW_W'(interval));
    scaled   = SUM_W'(sample) * SUM_W'(WINDOW_LEN);
    dev      = (scaled >= sum_r) ? (scaled - sum_r) : (sum_r - scaled);
    dev_x16  = (SUM_W + THR_W)'({dev, 4'b0000});
    sum_x_thr = (SUM_W + THR_W)'(sum_r) * (SUM_W + THR_W)'(threshold);
    take     = examine && ((sum_r == '0) || (dev_x16 <= sum_x_thr));

    sum_nxt     = sum_r;
    pos_nxt     = pos_r;
    wrapped_nxt = wrapped_r;
    if (take) begin
      sum_nxt     = sum_r - SUM_W'(oldest) + SUM_W'(sample);
      pos_nxt     = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
      wrapped_nxt = wrapped_r | (pos_r == POS_LAST);
    end
    last_nxt = examine ? item.now_ms : last_r;
    rd_addr  = proc_en ? pos_nxt : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      last_r    <= '0;
    end else if (proc_en) begin
      sum_r     <= sum_nxt;
      pos_r     <= pos_nxt;
      wrapped_r <= wrapped_nxt;
      last_r    <= last_nxt;
    end
  end

  // Write the accepted sample, prefetch the entry the pointer will face next
  always_ff @(posedge clk) begin
    if (proc_en && take) begin
      ring_r[pos_r] <= sample;
    end
    rd_r <= ring_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      sum_out_r        <= sum_nxt;
      flags_r.sampled  <= examine;
      flags_r.accepted <= take;
    end
  end

  assign sum_out   = sum_out_r;
  assign flags_out = flags_r;

endmodule

>>> hdl/ogma_scale.sv
module ogma_scale #(
  parameter int WINDOW_LEN  = ogma_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = ogma_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
  input  logic [SUM_W-1:0]            sum,
  output logic [ogma_pkg::FILT_W-1:0] level
);
  import ogma_pkg::*;

  // floor(sum / WINDOW_LEN) as (sum * ceil(2^K / WINDOW_LEN)) >> K, exact for sum < 2^SUM_W
  localparam int K      = SUM_W + $clog2(WINDOW_LEN);
  localparam int MW     = SUM_W + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam int PW     = SUM_W + MW;

  logic [PW-1:0]          prod;
  logic [SAMPLE_BITS-1:0] quot;

  always_comb begin
    prod  = PW'(sum) * PW'(RECIP);
    quot  = prod[K +: SAMPLE_BITS];
    level = FILT_W'(quot);
  end

endmodule

>>> hdl/outlier_gated_moving_average_unit.sv
// Outlier-gated moving average of a light-sensor reading.
// Input channel (in_valid / in_stall / in_data): one transaction per sensor
// sample, carrying a millisecond timestamp and the raw converter value.
// Result channel (out_valid / out_stall / out_data): exactly one transaction
// per input, carrying the filtered level and the sampled / accepted flags.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
// update interval (index 0) and the Q4.4 outlier threshold (index 1); write
// only while no transaction is in flight. cfg_ready is always high.
// A result passes the input register, then the core register (the state
// update), then the output register (the divide) before it appears.
// Throughput: one transaction per cycle unless out_stall holds the flow;
// the window sum, ring pointer and prefetched oldest entry update together.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the window sum,
// pointer and last-update time and restores the register defaults; the ring
// memory is not cleared, entries read as zero until the pointer first wraps.
// When the receiver stalls, the output holds; the stages behind it keep
// filling, and in_stall rises once all three stages are occupied.
module outlier_gated_moving_average_unit #(
  parameter int WINDOW_LEN  = ogma_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = ogma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ogma_pkg::ogma_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ogma_pkg::ogma_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ogma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ogma_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ogma_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);

  // Configuration registers
  logic [INTV_W-1:0] interval_r, interval_nxt;
  logic [THR_W-1:0]  thresh_r, thresh_nxt;

  // Pipeline control and payload
  logic        s1_valid_r, s1_valid_nxt;
  ogma_in_t    s1_item_r;
  logic        s2_valid_r, s2_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  ogma_out_t   out_data_r;
  logic        en_core, en_out, in_take;

  logic [SUM_W-1:0]  core_sum;
  ogma_flags_t       core_flags;
  logic [FILT_W-1:0] level;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    interval_nxt = interval_r;
    thresh_nxt   = thresh_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UPDATE_INTERVAL: interval_nxt = cfg_data;
        REG_OUTLIER_THRESH:  thresh_nxt   = THR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      thresh_r   <= THRESHOLD_RST;
    end else begin
      interval_r <= interval_nxt;
      thresh_r   <= thresh_nxt;
    end
  end

  // Advance each stage when the one ahead is empty or moving on
  always_comb begin
    en_out   = s2_valid_r && (!out_valid_r || !out_stall);
    en_core  = s1_valid_r && (!s2_valid_r || en_out);
    in_stall = s1_valid_r && !en_core;
    in_take  = in_valid && !in_stall;

    s1_valid_nxt  = in_take ? 1'b1 : (en_core ? 1'b0 : s1_valid_r);
    s2_valid_nxt  = en_core ? 1'b1 : (en_out ? 1'b0 : s2_valid_r);
    out_valid_nxt = en_out ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  // Interval gate, outlier test and window update
  ogma_core #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc_en  (en_core),
    .item     (s1_item_r),
    .interval (interval_r),
    .threshold(thresh_r),
    .sum_out  (core_sum),
    .flags_out(core_flags)
  );

  // Window sum to average
  ogma_scale #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_scale (
    .sum  (core_sum),
    .level(level)
  );

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r.filtered_value <= level;
      out_data_r.sampled        <= core_flags.sampled;
      out_data_r.accepted       <= core_flags.accepted;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A sample can only enter the window after it was examined
  a_accept_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (core_flags.sampled || !core_flags.accepted))
    else $error("accepted without sampled");

  // Never overwrite an occupied update stage that is not draining
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (en_core && s2_valid_r) |-> en_out)
    else $error("update stage overrun");

  // Reset empties every stage
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s2_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
